FILE: design/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, register indexes, pipeline records and saturation helpers
// for the point-to-pixel projection pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int DEF_FRAC_BITS = 16;

  localparam int PT_W    = 24;
  localparam int ROT_W   = 18;
  localparam int TRN_W   = 21;
  localparam int ROW_W   = 3 * ROT_W;
  localparam int TRS_W   = 3 * TRN_W;
  localparam int FOCAL_W = 16;
  localparam int DIM_W   = 12;
  localparam int SIZE_W  = 2 * DIM_W;
  localparam int HALF_W  = DIM_W - 1;
  localparam int PIX_W   = 16;

  // product of one rotation entry and one coordinate, and the row sum
  localparam int PROD_W = ROT_W + PT_W;
  localparam int ACC_W  = PROD_W + 2;
  // camera value, sized for the smallest supported fraction width (8)
  localparam int CAM_W  = ACC_W - 8 + 1;
  // numerator cam * focal
  localparam int NUM_W  = CAM_W + FOCAL_W + 1;
  // quotient bits kept before saturation
  localparam int QUO_W  = 17;
  // divider datapath width: holds the divisor shifted by QUO_W
  localparam int DIV_W  = CAM_W + 4 + QUO_W + 2;
  localparam int SUM_W  = QUO_W + 3;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 63;

  localparam logic [CFG_IDX_W-1:0] REG_ROT0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 3'd5;

  localparam logic [ROW_W-1:0]   ROT0_RST  = ROW_W'(65536);
  localparam logic [ROW_W-1:0]   ROT1_RST  = ROW_W'(64'd17179869184);
  localparam logic [ROW_W-1:0]   ROT2_RST  = ROW_W'(64'd4503599627370496);
  localparam logic [FOCAL_W-1:0] FOCAL_RST = FOCAL_W'(8400);
  localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(1966720);

  // one lane of the restoring divider
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             neg;   // quotient is negative
    logic             ovf;   // quotient magnitude beyond QUO_W bits
  } div_t;

  // data that rides alongside the divider
  typedef struct packed {
    logic [PT_W-1:0]   cam_x;
    logic [PT_W-1:0]   cam_y;
    logic [PT_W-1:0]   cam_z;
    logic              zero;
    logic              x_neg;
    logic              y_neg;
    logic [HALF_W-1:0] half_u;
    logic [HALF_W-1:0] half_v;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } side_t;

  // clamp a camera value to the 24-bit output range
  function automatic logic [PT_W-1:0] sat_cam(input logic [CAM_W-1:0] v);
    logic [CAM_W-PT_W:0] top;
    top = v[CAM_W-1:PT_W-1];
    if (top == '0 || top == '1) begin
      sat_cam = v[PT_W-1:0];
    end else if (v[CAM_W-1]) begin
      sat_cam = {1'b1, {(PT_W-1){1'b0}}};
    end else begin
      sat_cam = {1'b0, {(PT_W-1){1'b1}}};
    end
  endfunction

  // clamp a pixel sum to 16 bits signed
  function automatic logic [PIX_W-1:0] sat_pix(input logic [SUM_W-1:0] v);
    logic [SUM_W-PIX_W:0] top;
    top = v[SUM_W-1:PIX_W-1];
    if (top == '0 || top == '1) begin
      sat_pix = v[PIX_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat_pix = {1'b1, {(PIX_W-1){1'b0}}};
    end else begin
      sat_pix = {1'b0, {(PIX_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: design/ppp_xform.sv
// ----------------------------------------------------------------------------
// ppp_xform
// Rigid transform world -> camera: nine registered products, then row sums,
// floor shift and translation, registered.
// ----------------------------------------------------------------------------
module ppp_xform import ppp_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [PT_W-1:0]  px,
  input  logic signed [PT_W-1:0]  py,
  input  logic signed [PT_W-1:0]  pz,
  input  logic [ROW_W-1:0]        rot_row0,
  input  logic [ROW_W-1:0]        rot_row1,
  input  logic [ROW_W-1:0]        rot_row2,
  input  logic [TRS_W-1:0]        translation,
  output logic                    out_valid,
  output logic signed [CAM_W-1:0] cx,
  output logic signed [CAM_W-1:0] cy,
  output logic signed [CAM_W-1:0] cz
);

  logic [ROW_W-1:0]         rows [3];
  logic signed [PT_W-1:0]   pt   [3];
  logic signed [PROD_W-1:0] prod [9];
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc  [3];
  logic signed [CAM_W-1:0]  cam  [3];

  assign rows[0] = rot_row0;
  assign rows[1] = rot_row1;
  assign rows[2] = rot_row2;
  assign pt[0]   = px;
  assign pt[1]   = py;
  assign pt[2]   = pz;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[3*i+j] <= $signed(rows[i][ROT_W*j +: ROT_W]) * pt[j];
        end
      end
    end
  end

  // row sums, floor by shift, add translation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(prod[3*i]) + ACC_W'(prod[3*i+1]) + ACC_W'(prod[3*i+2]);
      cam[i] = CAM_W'(acc[i] >>> FRAC_BITS)
             + CAM_W'($signed(translation[TRN_W*i +: TRN_W]));
    end
  end

  // stage 2: camera coordinates
  always_ff @(posedge clk) begin
    if (adv) begin
      cx <= cam[0];
      cy <= cam[1];
      cz <= cam[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

endmodule

FILE: design/ppp_div_step.sv
// ----------------------------------------------------------------------------
// ppp_div_step
// One registered step of the restoring divider: resolves quotient bit SHIFT.
// ----------------------------------------------------------------------------
module ppp_div_step import ppp_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic clk,
  input  logic adv,
  input  div_t din,
  output div_t dout
);

  logic [DIV_W-1:0] sub;
  div_t             nxt;

  always_comb begin
    sub = din.den << SHIFT;
    nxt = din;
    if (din.rem >= sub) begin
      nxt.rem        = din.rem - sub;
      nxt.quo[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= nxt;
    end
  end

endmodule

FILE: design/project_point_to_pixel.sv
// ----------------------------------------------------------------------------
// project_point_to_pixel
// Pinhole projection of a world point: rotate, translate, divide by depth,
// scale by focal length, offset to image centre, floor and range check.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | point_x, point_y, point_z
//  out     | output    | out_valid/out_stall| pixel_u/v, in_image, depth_zero,
//          |           |                    | cam_x, cam_y, cam_z
//  cfg     | input     | cfg_valid/ready    | cfg_index, cfg_data
//
//  One point per cycle unless the output register is full and stalled; stages:
//  2 transform, 1 numerator multiply, 1 divider setup, 17 divider steps, 1 output register.
//  The 17-stage restoring divider sets the depth.
//  rst is synchronous; it empties the pipeline and loads register defaults.
//  The whole pipeline holds while the output register is full and stalled.
// ----------------------------------------------------------------------------
module project_point_to_pixel import ppp_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [PT_W-1:0] point_x,
  input  logic signed [PT_W-1:0] point_y,
  input  logic signed [PT_W-1:0] point_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PIX_W-1:0] pixel_u,
  output logic signed [PIX_W-1:0] pixel_v,
  output logic                   in_image,
  output logic                   depth_zero,
  output logic signed [PT_W-1:0] cam_x,
  output logic signed [PT_W-1:0] cam_y,
  output logic signed [PT_W-1:0] cam_z,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic [ROW_W-1:0]   rot_row0, rot_row1, rot_row2;
  logic [TRS_W-1:0]   translation;
  logic [FOCAL_W-1:0] focal_length;
  logic [SIZE_W-1:0]  image_size;

  logic adv;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row0     <= ROT0_RST;
      rot_row1     <= ROT1_RST;
      rot_row2     <= ROT2_RST;
      translation  <= '0;
      focal_length <= FOCAL_RST;
      image_size   <= SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROT0:  rot_row0     <= cfg_data[ROW_W-1:0];
        REG_ROT1:  rot_row1     <= cfg_data[ROW_W-1:0];
        REG_ROT2:  rot_row2     <= cfg_data[ROW_W-1:0];
        REG_TRANS: translation  <= cfg_data[TRS_W-1:0];
        REG_FOCAL: focal_length <= cfg_data[FOCAL_W-1:0];
        REG_SIZE:  image_size   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: move when the output register is free or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // world -> camera
  logic                    xf_valid;
  logic signed [CAM_W-1:0] cx, cy, cz;

  ppp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .px          (point_x),
    .py          (point_y),
    .pz          (point_z),
    .rot_row0    (rot_row0),
    .rot_row1    (rot_row1),
    .rot_row2    (rot_row2),
    .translation (translation),
    .out_valid   (xf_valid),
    .cx          (cx),
    .cy          (cy),
    .cz          (cz)
  );

  // stage 3: numerators, divisor magnitude, side data
  logic                    s3_valid;
  logic signed [NUM_W-1:0] num_u, num_v;
  logic [DIV_W-1:0]        den;
  logic                    z_neg;
  side_t                   s3_side;
  logic [CAM_W-1:0]        z_mag;

  assign z_mag = cz[CAM_W-1] ? CAM_W'(-cz) : CAM_W'(cz);

  always_ff @(posedge clk) begin
    if (adv) begin
      num_u          <= cx * $signed({1'b0, focal_length});
      num_v          <= cy * $signed({1'b0, focal_length});
      den            <= DIV_W'(z_mag) << 4;
      z_neg          <= cz[CAM_W-1];
      s3_side.cam_x  <= sat_cam(cx);
      s3_side.cam_y  <= sat_cam(cy);
      s3_side.cam_z  <= sat_cam(cz);
      s3_side.zero   <= (cz == '0);
      s3_side.x_neg  <= cx[CAM_W-1];
      s3_side.y_neg  <= cy[CAM_W-1];
      s3_side.width  <= image_size[DIM_W-1:0];
      s3_side.height <= image_size[SIZE_W-1:DIM_W];
      s3_side.half_u <= image_size[DIM_W-1:1];
      s3_side.half_v <= image_size[SIZE_W-1:DIM_W+1];
    end
  end

  // stage 4: magnitudes and range check, then divider steps
  div_t             div_u [QUO_W+1];
  div_t             div_v [QUO_W+1];
  side_t            side  [QUO_W+1];
  logic [QUO_W:0]   vld;
  logic [DIV_W-1:0] mag_u, mag_v, lim;

  assign mag_u = num_u[NUM_W-1] ? DIV_W'($unsigned(-num_u)) : DIV_W'($unsigned(num_u));
  assign mag_v = num_v[NUM_W-1] ? DIV_W'($unsigned(-num_v)) : DIV_W'($unsigned(num_v));
  assign lim   = den << QUO_W;

  always_ff @(posedge clk) begin
    if (adv) begin
      div_u[0] <= '{rem: mag_u, den: den, quo: '0,
                    neg: num_u[NUM_W-1] ^ z_neg, ovf: mag_u >= lim};
      div_v[0] <= '{rem: mag_v, den: den, quo: '0,
                    neg: num_v[NUM_W-1] ^ z_neg, ovf: mag_v >= lim};
      side[0]  <= s3_side;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    ppp_div_step #(.SHIFT(QUO_W-1-k)) u_step_u (
      .clk  (clk),
      .adv  (adv),
      .din  (div_u[k]),
      .dout (div_u[k+1])
    );
    ppp_div_step #(.SHIFT(QUO_W-1-k)) u_step_v (
      .clk  (clk),
      .adv  (adv),
      .din  (div_v[k]),
      .dout (div_v[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        side[k+1] <= side[k];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      vld      <= '0;
    end else if (adv) begin
      s3_valid <= xf_valid;
      vld      <= {vld[QUO_W-1:0], s3_valid};
    end
  end

  // floor correction, centre offset, saturation
  function automatic logic [PIX_W-1:0] finish(input div_t d, input logic zero,
                                              input logic num_neg,
                                              input logic [HALF_W-1:0] half);
    logic [QUO_W+1:0] qs;
    logic [SUM_W-1:0] sum;
    qs  = d.neg ? ((QUO_W+2)'(0) - (QUO_W+2)'(d.quo) - (QUO_W+2)'(d.rem != '0))
                : (QUO_W+2)'(d.quo);
    sum = {qs[QUO_W+1], qs} + SUM_W'(half);
    if (zero) begin
      finish = num_neg ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
    end else if (d.ovf) begin
      finish = d.neg ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
    end else begin
      finish = sat_pix(sum);
    end
  endfunction

  side_t                   sd;
  logic signed [PIX_W-1:0] u_fin, v_fin;
  logic                    in_img;

  assign sd     = side[QUO_W];
  assign u_fin  = $signed(finish(div_u[QUO_W], sd.zero, sd.x_neg, sd.half_u));
  assign v_fin  = $signed(finish(div_v[QUO_W], sd.zero, sd.y_neg, sd.half_v));
  assign in_img = !sd.zero && !u_fin[PIX_W-1] && !v_fin[PIX_W-1]
               && (u_fin < $signed({{(PIX_W-DIM_W){1'b0}}, sd.width}))
               && (v_fin < $signed({{(PIX_W-DIM_W){1'b0}}, sd.height}));

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_u    <= u_fin;
      pixel_v    <= v_fin;
      in_image   <= in_img;
      depth_zero <= sd.zero;
      cam_x      <= sd.cam_x;
      cam_y      <= sd.cam_y;
      cam_z      <= sd.cam_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[QUO_W];
    end
  end

`ifndef SYNTH
  // a zero-depth request never lands inside the image
  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && depth_zero |-> !in_image)
    else $error("in_image set with zero depth");

  // inside the image means non-negative coordinates
  a_inside_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_image |-> !pixel_u[PIX_W-1] && !pixel_v[PIX_W-1])
    else $error("in_image set with negative pixel");

  // the input holds back only behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall without output back-pressure");

  // a request leaving the divider reaches the output on the next advance
  a_drain: assert property (@(posedge clk) disable iff (rst)
    adv && vld[QUO_W] |=> out_valid)
    else $error("request lost at output register");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams world points through the projection pipeline under random input
// gaps and output stalls, predicts every pixel and camera point in the
// testbench, and checks results in order across several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import ppp_pkg::*;

  localparam int FRAC     = 16;
  localparam int LATENCY  = 22;
  localparam int MAX_CYC  = 1500000;

  // index past the register list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic signed [PT_W-1:0] x, y, z;
  } point_t;

  typedef struct {
    logic signed [PIX_W-1:0] u, v;
    logic                    in_img, zero;
    logic signed [PT_W-1:0]  cx, cy, cz;
  } pixel_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [PT_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [PIX_W-1:0] pixel_u, pixel_v;
  logic in_image, depth_zero;
  logic signed [PT_W-1:0] cam_x, cam_y, cam_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // register shadow
  logic [ROW_W-1:0]   rot_sh [3];
  logic [TRS_W-1:0]   trans_sh;
  logic [FOCAL_W-1:0] focal_sh;
  logic [SIZE_W-1:0]  size_sh;

  point_t     point_q[$];
  pixel_rec_t pixel_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_out = 1'b0;
  int hold_cnt = 0;
  bit send_gap_on = 1'b1;
  bit recv_gap_on = 1'b1;

  project_point_to_pixel i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint fdiv(longint n, longint d);
    longint q, r;
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) != (d < 0))) q -= 1;
    return q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // one projected pixel for a camera numerator
  function automatic longint to_pixel(longint num, longint z, longint half, bit zero);
    if (zero) return num < 0 ? -32768 : 32767;
    return clamp(fdiv(num * longint'(focal_sh), z * 16) + half, -32768, 32767);
  endfunction

  function automatic pixel_rec_t project_point(point_t p);
    pixel_rec_t r;
    longint pv[3], cam[3], acc, w, h, u, v;
    logic signed [ROT_W-1:0] e;
    logic signed [TRN_W-1:0] t;
    pv[0] = longint'(p.x); pv[1] = longint'(p.y); pv[2] = longint'(p.z);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        e = rot_sh[i][ROT_W*j +: ROT_W];
        acc += longint'(e) * pv[j];
      end
      t = trans_sh[TRN_W*i +: TRN_W];
      cam[i] = fdiv(acc, longint'(1) << FRAC) + longint'(t);
    end
    w = longint'(size_sh[11:0]);
    h = longint'(size_sh[23:12]);
    r.zero = (cam[2] == 0);
    u = to_pixel(cam[0], cam[2], w >> 1, r.zero);
    v = to_pixel(cam[1], cam[2], h >> 1, r.zero);
    r.in_img = !r.zero && u >= 0 && u < w && v >= 0 && v < h;
    r.u = u[15:0];
    r.v = v[15:0];
    r.cx = PT_W'(clamp(cam[0], -8388608, 8388607));
    r.cy = PT_W'(clamp(cam[1], -8388608, 8388607));
    r.cz = PT_W'(clamp(cam[2], -8388608, 8388607));
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // driver: offers queued points, predicts at acceptance
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pixel_q.push_back(project_point('{point_x, point_y, point_z}));
        void'(point_q.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if ((in_valid && !in_stall ? point_q.size() > 0 : point_q.size() > 0)) begin
          in_valid <= 1'b1;
          point_x  <= point_q[0].x;
          point_y  <= point_q[0].y;
          point_z  <= point_q[0].z;
          if (send_gap_on) send_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, long hold-off on request, compare in order
  int recv_gap = 0;
  always @(posedge clk) begin
    pixel_rec_t exp_r;
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("[project_point_to_pixel] ERROR");
      $finish;
    end
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $error("result with none expected");
          errors++;
        end else begin
          exp_r = pixel_q.pop_front();
          if (pixel_u !== exp_r.u) begin
            $error("pixel_u exp %0d got %0d", exp_r.u, pixel_u); errors++;
          end
          if (pixel_v !== exp_r.v) begin
            $error("pixel_v exp %0d got %0d", exp_r.v, pixel_v); errors++;
          end
          if (in_image !== exp_r.in_img) begin
            $error("in_image exp %0d got %0d", exp_r.in_img, in_image); errors++;
          end
          if (depth_zero !== exp_r.zero) begin
            $error("depth_zero exp %0d got %0d", exp_r.zero, depth_zero);
            errors++;
          end
          if (cam_x !== exp_r.cx) begin
            $error("cam_x exp %0d got %0d", exp_r.cx, cam_x); errors++;
          end
          if (cam_y !== exp_r.cy) begin
            $error("cam_y exp %0d got %0d", exp_r.cy, cam_y); errors++;
          end
          if (cam_z !== exp_r.cz) begin
            $error("cam_z exp %0d got %0d", exp_r.cz, cam_z); errors++;
          end
        end
      end
      if (hold_out) begin
        out_stall <= 1'b1;
        if (hold_cnt >= 120) begin
          hold_out <= 1'b0;
          hold_cnt <= 0;
        end else begin
          hold_cnt <= hold_cnt + 1;
        end
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (recv_gap_on && $urandom_range(0, 3) == 0) recv_gap <= gap_len();
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROT0:  rot_sh[0] = val[ROW_W-1:0];
      REG_ROT1:  rot_sh[1] = val[ROW_W-1:0];
      REG_ROT2:  rot_sh[2] = val[ROW_W-1:0];
      REG_TRANS: trans_sh  = val[TRS_W-1:0];
      REG_FOCAL: focal_sh  = val[FOCAL_W-1:0];
      REG_SIZE:  size_sh   = val[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (point_q.size() > 0 || in_valid || pixel_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [PT_W-1:0] rand_coord(int mode);
    case (mode)
      0: return PT_W'($urandom);
      1: return PT_W'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
      default: return PT_W'($signed($urandom_range(0, 2 ** 18)) + 2 ** 16);
    endcase
  endfunction

  function automatic logic [ROT_W-1:0] rand_rot();
    case ($urandom_range(0, 3))
      0: return ROT_W'($urandom);
      1: return ROT_W'(65536);
      2: return '0;
      default: return ROT_W'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  task automatic random_points(int n);
    int mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(0, 3);
      point_q.push_back('{rand_coord(mode), rand_coord(mode), rand_coord(mode == 0 ? 0 : 2)});
    end
  endtask

  initial begin
    logic [PT_W-1:0] edge_v[5];
    edge_v = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h010000};
    rot_sh[0] = ROT0_RST; rot_sh[1] = ROT1_RST; rot_sh[2] = ROT2_RST;
    trans_sh = '0; focal_sh = FOCAL_RST; size_sh = SIZE_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, extremes, zero depth, behind camera, off-image
    for (int a = 0; a < 5; a++)
      for (int b = 0; b < 4; b++) point_q.push_back('{edge_v[a], edge_v[b], edge_v[(a + b) % 5]});
    point_q.push_back('{24'h000000, 24'h000000, 24'h000000});
    point_q.push_back('{24'hFF0000, 24'h010000, 24'h000000});
    point_q.push_back('{24'h010000, 24'hFF0000, 24'hFF0000});
    point_q.push_back('{24'h7FFFFF, 24'h800000, 24'h000001});
    drain();

    // zero focal, zero image, translation extremes
    write_reg(REG_FOCAL, '0);
    write_reg(REG_SIZE, '0);
    write_reg(REG_TRANS, {21'h100000, 21'h0FFFFF, 21'h1FFFFF});
    random_points(60);
    drain();

    // maximal registers
    write_reg(REG_ROT0, CFG_W'({3{18'h1FFFF}}));
    write_reg(REG_ROT1, CFG_W'({3{18'h20000}}));
    write_reg(REG_ROT2, CFG_W'({18'h3FFFF, 18'h00001, 18'h20000}));
    write_reg(REG_TRANS, '1);
    write_reg(REG_FOCAL, CFG_W'(16'hFFFF));
    write_reg(REG_SIZE, CFG_W'(24'hFFFFFF));
    write_reg(REG_NONE, '1);
    random_points(200);
    drain();

    // several random settings; one with a long output hold
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_ROT0, CFG_W'({rand_rot(), rand_rot(), rand_rot()}));
      write_reg(REG_ROT1, CFG_W'({rand_rot(), rand_rot(), rand_rot()}));
      write_reg(REG_ROT2, CFG_W'({rand_rot(), rand_rot(), rand_rot()}));
      write_reg(REG_TRANS, CFG_W'({$urandom, $urandom}));
      write_reg(REG_FOCAL, ($urandom_range(0, 1)) ? CFG_W'($urandom_range(1, 65535))
                                                  : CFG_W'(16'd8400));
      write_reg(REG_SIZE, ($urandom_range(0, 1)) ? CFG_W'($urandom) : CFG_W'(SIZE_RST));
      send_gap_on = (ph != 2);
      recv_gap_on = (ph != 3);
      if (ph == 1) hold_out = 1'b1;
      random_points(ph == 1 ? 300 : 200);
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("[project_point_to_pixel] OK");
    end else begin
      $display("[project_point_to_pixel] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ppp_pkg.sv
design/ppp_xform.sv
design/ppp_div_step.sv
design/project_point_to_pixel.sv
tb/tb_top.sv
